// ----- sv/spct_pkg.sv -----
// spct_pkg: shared constants, register codes and beat types for the
// segment closest point / sphere test block; depends on nothing else
package spct_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int DIST_W      = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5,
        REG_DEGEN   = 3'd6
    } t_cfg_reg;

    // query beat
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic [COORD_WIDTH-2:0]        radius;
    } t_query;

    // result beat
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] closest_x;
        logic signed [COORD_WIDTH-1:0] closest_y;
        logic signed [COORD_WIDTH-1:0] closest_z;
        logic [FRAC_BITS:0]            param_t;
        logic [DIST_W-1:0]             dist_sq;
        logic                          hit;
    } t_result;

    // control handed from cell to cell
    typedef struct packed {
        logic valid;
        logic skip;
    } t_div_ctl;

endpackage

// ----- sv/spct_div_cell.sv -----
// spct_div_cell: one restoring-division step of the parameter divider chain
// depends on spct_pkg (t_div_ctl, t_query)
module spct_div_cell #(
    parameter int LW = 66,
    parameter int TW = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spct_pkg::t_div_ctl  i_ctl,
    input  logic [LW-1:0]       i_rem,
    input  logic [LW-1:0]       i_len,
    input  logic [TW-1:0]       i_t,
    input  spct_pkg::t_query    i_query,
    output spct_pkg::t_div_ctl  o_ctl,
    output logic [LW-1:0]       o_rem,
    output logic [LW-1:0]       o_len,
    output logic [TW-1:0]       o_t,
    output spct_pkg::t_query    o_query
);

    logic [LW:0]   rem2;
    logic          ge;
    logic [LW-1:0] n_rem;
    logic [TW-1:0] n_t;

    spct_pkg::t_div_ctl r_ctl;
    logic [LW-1:0]      r_rem;
    logic [LW-1:0]      r_len;
    logic [TW-1:0]      r_t;
    spct_pkg::t_query   r_query;

    // shift, compare, subtract; settled items pass unchanged
    always_comb begin
        rem2 = {i_rem, 1'b0};
        ge   = rem2 >= {1'b0, i_len};
        if (i_ctl.skip) begin
            n_rem = i_rem;
            n_t   = i_t;
        end else if (ge) begin
            n_rem = LW'(rem2 - {1'b0, i_len});
            n_t   = {i_t[TW-2:0], 1'b1};
        end else begin
            n_rem = rem2[LW-1:0];
            n_t   = {i_t[TW-2:0], 1'b0};
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_len   <= i_len;
        r_t     <= n_t;
        r_query <= i_query;
    end

    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_len   = r_len;
    assign o_t     = r_t;
    assign o_query = r_query;

endmodule

// ----- sv/segment_point_closest_sphere_test_top.sv -----
// segment_point_closest_sphere_test_top: closest point on a segment and
// sphere hit test; depends on spct_pkg and spct_div_cell
//
// Usage: the segment end points and the degenerate squared-length threshold are
// written through the configuration channel (i_cfg_valid / o_cfg_ready,
// i_cfg_index, i_cfg_data); o_cfg_ready is always high. Write only while
// no query is in flight.
// A query beat (i_query) is taken at each clock edge with start high and
// busy low. busy is high only in reset and until r_up is set, so a new
// query can be given every cycle: throughput is one beat per cycle.
// Each query gives exactly one result beat on o_result, marked by
// o_result_valid for one cycle, and the beat is taken at the edge that
// follows. The query passes through four setup stages (the first is the
// input register), the divider chain of FRAC_BITS cells, one quotient
// bit each, and five back-end stages (scale, round, square, sum,
// saturate and compare).
// Reset clears all in-flight queries and the configuration registers to 0.
// The receiver cannot stall; results must be taken as they appear.
module segment_point_closest_sphere_test_top #(
    parameter int CW = spct_pkg::COORD_WIDTH,
    parameter int FB = spct_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  spct_pkg::t_query                    i_query,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_result_valid,
    output spct_pkg::t_result                   o_result
);

    localparam int DW   = CW + 1;
    localparam int LW   = 2 * DW;
    localparam int DTW  = LW + 1;
    localparam int TW   = FB + 1;
    localparam int MW   = DW + TW + 1;
    localparam int EW   = CW + 1;
    localparam int SW   = 2 * EW + 2;
    localparam int RW   = 2 * (CW - 1);
    localparam int XW   = (SW > spct_pkg::DIST_W) ? SW : spct_pkg::DIST_W + 1;
    localparam int CMPW = (LW > spct_pkg::DIST_W) ? LW : spct_pkg::DIST_W;
    localparam int LAT  = FB + 8;

    // configuration registers and derived direction
    logic signed [CW-1:0]          r_s [3];
    logic signed [CW-1:0]          r_e [3];
    logic [spct_pkg::DIST_W-1:0]   r_degen;
    logic signed [DW-1:0]          r_d [3];
    logic                          r_up;
    logic                          accept;

    assign busy        = ~r_up | ~i_rst_n;
    assign accept      = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // reset release flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= 1'b0;
        end else begin
            r_up <= 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= '0;
                r_e[i] <= '0;
            end
            r_degen <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (spct_pkg::t_cfg_reg'(i_cfg_index))
                spct_pkg::REG_START_X: r_s[0] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_START_Y: r_s[1] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_START_Z: r_s[2] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_END_X:   r_e[0] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_END_Y:   r_e[1] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_END_Z:   r_e[2] <= i_cfg_data[CW-1:0];
                spct_pkg::REG_DEGEN:   r_degen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // segment direction, refreshed every cycle from the registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i] <= {r_e[i][CW-1], r_e[i]} - {r_s[i][CW-1], r_s[i]};
        end
    end

    // valid chain of the setup and back-end stages
    logic r_v0, r_v1, r_v2, r_v3, r_vp1, r_vp2, r_vp3, r_vp4;

    // stage 0: point minus start
    logic signed [CW-1:0] pin [3];
    logic signed [DW-1:0] r_w [3];
    spct_pkg::t_query     r_q0, r_q1, r_q2, r_q3;

    assign pin[0] = i_query.point_x;
    assign pin[1] = i_query.point_y;
    assign pin[2] = i_query.point_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_w[i] <= {pin[i][CW-1], pin[i]} - {r_s[i][CW-1], r_s[i]};
        end
        r_q0 <= i_query;
    end

    // stage 1: squares of the direction and dot terms
    logic signed [LW-1:0] r_dd [3];
    logic signed [LW-1:0] r_wd [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dd[i] <= r_d[i] * r_d[i];
            r_wd[i] <= r_w[i] * r_d[i];
        end
        r_q1 <= r_q0;
    end

    // stage 2: squared length and dot product
    logic [LW-1:0]         r_len2;
    logic signed [DTW-1:0] r_dot;

    always_ff @(posedge i_clk) begin
        r_len2 <= LW'(r_dd[0]) + LW'(r_dd[1]) + LW'(r_dd[2]);
        r_dot  <= DTW'(r_wd[0]) + DTW'(r_wd[1]) + DTW'(r_wd[2]);
        r_q2   <= r_q1;
    end

    // stage 3: clamp decisions and divider seed
    logic               degen, nonpos, sat;
    spct_pkg::t_div_ctl r_ctl3;
    logic [LW-1:0]      r_rem3, r_len3;
    logic [TW-1:0]      r_t3;

    always_comb begin
        degen  = CMPW'(r_len2) <= CMPW'(r_degen);
        nonpos = r_dot <= 0;
        sat    = r_dot[LW-1:0] >= r_len2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3.valid <= 1'b0;
        end else begin
            r_ctl3.valid <= r_v2;
        end
        r_ctl3.skip  <= degen | nonpos | sat;
        r_rem3       <= r_dot[LW-1:0];
        r_len3       <= r_len2;
        r_t3         <= (!degen && !nonpos && sat) ? {1'b1, {FB{1'b0}}} : '0;
        r_q3         <= r_q2;
    end

    // divider chain: one quotient bit per cell
    spct_pkg::t_div_ctl c_ctl [FB+1];
    logic [LW-1:0]      c_rem [FB+1];
    logic [LW-1:0]      c_len [FB+1];
    logic [TW-1:0]      c_t   [FB+1];
    spct_pkg::t_query   c_q   [FB+1];

    assign c_ctl[0] = r_ctl3;
    assign c_rem[0] = r_rem3;
    assign c_len[0] = r_len3;
    assign c_t[0]   = r_t3;
    assign c_q[0]   = r_q3;

    for (genvar k = 0; k < FB; k++) begin : g_cell
        spct_div_cell #(
            .LW (LW),
            .TW (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_rem   (c_rem[k]),
            .i_len   (c_len[k]),
            .i_t     (c_t[k]),
            .i_query (c_q[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_len   (c_len[k+1]),
            .o_t     (c_t[k+1]),
            .o_query (c_q[k+1])
        );
    end

    // back end stage 1: direction times parameter
    logic signed [MW-1:0] r_prod [3];
    logic [TW-1:0]        r_tp1, r_tp2, r_tp3, r_tp4;
    spct_pkg::t_query     r_qp1, r_qp2;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= r_d[i] * $signed({1'b0, c_t[FB]});
        end
        r_tp1 <= c_t[FB];
        r_qp1 <= c_q[FB];
    end

    // back end stage 2: round to nearest, ties up, and add start
    logic signed [MW-1:0] rnd [3];
    logic signed [CW-1:0] r_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (r_prod[i] + (MW'(1) <<< (FB - 1))) >>> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= r_s[i] + rnd[i][CW-1:0];
        end
        r_tp2 <= r_tp1;
        r_qp2 <= r_qp1;
    end

    // back end stage 3: squared error terms and radius squared
    logic signed [CW-1:0]   pp2 [3];
    logic signed [EW-1:0]   err [3];
    logic signed [2*EW-1:0] r_e2 [3];
    logic [RW-1:0]          r_rad2_3, r_rad2_4;
    logic signed [CW-1:0]   r_cp3 [3];
    logic signed [CW-1:0]   r_cp4 [3];

    assign pp2[0] = r_qp2.point_x;
    assign pp2[1] = r_qp2.point_y;
    assign pp2[2] = r_qp2.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            err[i] = {r_c[i][CW-1], r_c[i]} - {pp2[i][CW-1], pp2[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e2[i]  <= err[i] * err[i];
            r_cp3[i] <= r_c[i];
        end
        r_rad2_3 <= r_qp2.radius * r_qp2.radius;
        r_tp3    <= r_tp2;
    end

    // back end stage 4: squared distance
    logic [SW-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        r_dist   <= SW'(unsigned'(r_e2[0])) + SW'(unsigned'(r_e2[1]))
                  + SW'(unsigned'(r_e2[2]));
        r_rad2_4 <= r_rad2_3;
        r_tp4    <= r_tp3;
        for (int i = 0; i < 3; i++) begin
            r_cp4[i] <= r_cp3[i];
        end
    end

    // output stage: saturate and compare
    logic [XW-1:0]    distx;
    spct_pkg::t_result n_res, r_res;

    always_comb begin
        distx             = XW'(r_dist);
        n_res.closest_x   = r_cp4[0];
        n_res.closest_y   = r_cp4[1];
        n_res.closest_z   = r_cp4[2];
        n_res.param_t     = r_tp4;
        n_res.dist_sq     = (|distx[XW-1:spct_pkg::DIST_W]) ? '1
                          : distx[spct_pkg::DIST_W-1:0];
        n_res.hit         = XW'(r_rad2_4) >= distx;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
            r_vp3 <= 1'b0;
            r_vp4 <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_v0  <= accept;
            r_v1  <= r_v0;
            r_v2  <= r_v1;
            r_vp1 <= c_ctl[FB].valid;
            r_vp2 <= r_vp1;
            r_vp3 <= r_vp2;
            r_vp4 <= r_vp3;
            r_v3  <= r_vp4;
        end
    end

    assign o_result_valid = r_v3;
    assign o_result       = r_res;

    // every result beat traces back to an accepted query
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, LAT + 1))
        else $error("result beat without matching query");

    // a saturated distance never counts as a hit
    a_sat_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.hit) |-> (o_result.dist_sq != '1))
        else $error("hit reported on saturated distance");

    // the clamped parameter never exceeds one
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.param_t <= {1'b1, {FB{1'b0}}}))
        else $error("parameter above one");

endmodule
